[hdl/topk_pkg.sv]
// ----------------------------------------------------------------------------
// topk_pkg
// Shared word types, register indexes, status codes and the control/status
// structs between the top-k controller and its datapath.
// ----------------------------------------------------------------------------
package topk_pkg;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 5;
  localparam int SEL_COUNT_W = 5;
  localparam int STATUS_W    = 2;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SELECT_COUNT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PICK_LARGEST = 2'd1;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_SHORT = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_LONG  = 2'd2;

  // reset values of the registers
  localparam logic [SEL_COUNT_W-1:0] SELECT_COUNT_RESET = 5'd1;
  localparam logic                   PICK_LARGEST_RESET = 1'b1;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      row_end;
  } in_word_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value_out;
    logic [POS_W-1:0]          position_out;
    logic                      last_result;
    logic [STATUS_W-1:0]       status;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic accept;   // input word taken this cycle
    logic row_end;  // accepted word closes the row
    logic load;     // move next result into the output register
    logic clear;    // row finished, reset row state
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_valid;  // output register holds a word
    logic last_load;  // next load is the final result of the row
  } dp_status_t;

endpackage

[hdl/topk_select_with_indices.sv]
// ----------------------------------------------------------------------------
// topk_select_with_indices
// Streaming top-k selection over a row of signed 32-bit values, returning
// the k best values with their row positions, best first.
// ----------------------------------------------------------------------------
// Usage:
//   in channel: one value word per accepted cycle, row_end on the row's last
//   word. Each word is placed by a compare-and-shift insertion across K_MAX
//   cells, so a row streams in at one word per cycle while in_ready is high.
//   out channel: after the row_end word, the first result goes to the output
//   register; results follow at one word per cycle while out_ready is
//   high, best first, last_result set on the final one. A short row (fewer
//   than k words) or an overlong row (more than ROW_MAX words) gives a single
//   word with status set and value and position zero.
//   A row is taken in word by word, then k results (one on error) are drained
//   from the cell row; in_ready is low during the drain and the next row
//   may start while the final result still waits in the output register.
//   A stalled receiver holds the output register and the drain pauses.
//   cfg port: select_count (index 0) and pick_largest (index 1), written
//   with cfg_write; k is taken at row end, pick_largest at each insertion.
//   Reset (rst, synchronous) empties the row, clears the output and sets
//   select_count to 1 and pick_largest to 1.
// ----------------------------------------------------------------------------
module topk_select_with_indices #(
  parameter int K_MAX   = 16,
  parameter int ROW_MAX = 65536
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  topk_pkg::in_word_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output topk_pkg::out_word_t              out_data,
  input  logic                             cfg_write,
  input  logic [topk_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [topk_pkg::CFG_DATA_W-1:0]  cfg_data
);

  topk_pkg::dp_cmd_t    cmd;
  topk_pkg::dp_status_t st;

  // sequencer
  topk_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_row_end (in_data.row_end),
    .out_ready  (out_ready),
    .st         (st),
    .cmd        (cmd)
  );

  // cells, counters and output register
  topk_datapath #(
    .K_MAX   (K_MAX),
    .ROW_MAX (ROW_MAX)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_data  (out_data),
    .out_valid (out_valid),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

[hdl/topk_ctrl.sv]
// ----------------------------------------------------------------------------
// topk_ctrl
// Sequencer for the top-k block: collects a row, then drains the results
// one word per free output slot.
// ----------------------------------------------------------------------------
module topk_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_row_end,
  input  logic                out_ready,
  input  topk_pkg::dp_status_t st,
  output topk_pkg::dp_cmd_t    cmd
);

  typedef enum logic [0:0] {
    ST_COLLECT,
    ST_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   load;

  // output slot free for the next result
  assign load = (state == ST_EMIT) && (!st.out_valid || out_ready);

  // command decode
  always_comb begin
    in_ready    = (state == ST_COLLECT);
    cmd.accept  = in_valid && in_ready;
    cmd.row_end = cmd.accept && in_row_end;
    cmd.load    = load;
    cmd.clear   = load && st.last_load;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_COLLECT: begin
        if (cmd.row_end) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (cmd.clear) state_next = ST_COLLECT;
      end
      default: state_next = ST_COLLECT;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COLLECT;
    end else begin
      state <= state_next;
    end
  end

endmodule

[hdl/topk_datapath.sv]
// ----------------------------------------------------------------------------
// topk_datapath
// Sorted row of K_MAX compare-and-shift cells, row counters, configuration
// registers and the output register.
// ----------------------------------------------------------------------------
module topk_datapath #(
  parameter int K_MAX   = 16,
  parameter int ROW_MAX = 65536
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  topk_pkg::in_word_t                   in_data,
  input  logic                                 out_ready,
  output topk_pkg::out_word_t                  out_data,
  output logic                                 out_valid,
  input  logic                                 cfg_write,
  input  logic [topk_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [topk_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  topk_pkg::dp_cmd_t                    cmd,
  output topk_pkg::dp_status_t                 st
);

  localparam int FW = $clog2(K_MAX + 1);
  localparam int RW = $clog2(ROW_MAX + 1);
  localparam int CW = ((RW > FW) ? RW : FW) + 1;

  // configuration
  logic [topk_pkg::SEL_COUNT_W-1:0] select_count;
  logic                             pick_largest;

  // kept list, best first
  logic signed [topk_pkg::VALUE_W-1:0] cell_value [K_MAX];
  logic [topk_pkg::POS_W-1:0]          cell_pos   [K_MAX];

  logic [FW-1:0]                filled;
  logic [RW-1:0]                row_position;
  logic [FW-1:0]                remain;
  logic [topk_pkg::STATUS_W-1:0] err;

  logic [K_MAX-1:0]             goes_before;
  logic [K_MAX-1:0]             ahead;
  logic                         at_max;
  logic                         do_insert;
  logic [FW-1:0]                k_eff;
  logic [CW-1:0]                count_new;
  logic [topk_pkg::POS_W-1:0]   new_pos;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      select_count <= topk_pkg::SELECT_COUNT_RESET;
      pick_largest <= topk_pkg::PICK_LARGEST_RESET;
    end else if (cfg_write) begin
      if (cfg_index == topk_pkg::REG_SELECT_COUNT) begin
        select_count <= cfg_data;
      end else if (cfg_index == topk_pkg::REG_PICK_LARGEST) begin
        pick_largest <= cfg_data[0];
      end
    end
  end

  // k clamped to 1..K_MAX
  always_comb begin
    if (select_count == '0) begin
      k_eff = FW'(1);
    end else if (int'(select_count) > K_MAX) begin
      k_eff = FW'(K_MAX);
    end else begin
      k_eff = FW'(select_count);
    end
  end

  assign at_max    = (row_position == RW'(ROW_MAX));
  assign do_insert = cmd.accept && !at_max;
  assign count_new = CW'(row_position) + CW'(1);
  assign new_pos   = topk_pkg::POS_W'(row_position);

  // per cell: new word beats this cell; ahead marks cells past the first hit
  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int i = 0; i < K_MAX; i++) begin
      if (FW'(i) < filled) begin
        goes_before[i] = pick_largest ? (in_data.value > cell_value[i])
                                      : (in_data.value < cell_value[i]);
      end else begin
        goes_before[i] = 1'b1;
      end
      ahead[i] = seen;
      seen     = seen | goes_before[i];
    end
  end

  // compare-and-shift cells; drain shifts toward cell 0
  for (genvar g = 0; g < K_MAX; g++) begin : g_cell
    if (g == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (do_insert && goes_before[0]) begin
          cell_value[0] <= in_data.value;
          cell_pos[0]   <= new_pos;
        end else if (cmd.load) begin
          if (K_MAX > 1) begin
            cell_value[0] <= cell_value[(K_MAX > 1) ? 1 : 0];
            cell_pos[0]   <= cell_pos[(K_MAX > 1) ? 1 : 0];
          end
        end
      end
    end else begin : g_body
      always_ff @(posedge clk) begin
        if (do_insert && ahead[g]) begin
          cell_value[g] <= cell_value[g-1];
          cell_pos[g]   <= cell_pos[g-1];
        end else if (do_insert && goes_before[g]) begin
          cell_value[g] <= in_data.value;
          cell_pos[g]   <= new_pos;
        end else if (cmd.load && (g < K_MAX - 1)) begin
          cell_value[g] <= cell_value[(g < K_MAX - 1) ? g + 1 : g];
          cell_pos[g]   <= cell_pos[(g < K_MAX - 1) ? g + 1 : g];
        end
      end
    end
  end

  // row counters, result count and error code
  always_ff @(posedge clk) begin
    if (rst) begin
      filled       <= '0;
      row_position <= '0;
      remain       <= '0;
      err          <= topk_pkg::STATUS_OK;
    end else begin
      if (cmd.clear) begin
        filled       <= '0;
        row_position <= '0;
      end else if (do_insert) begin
        row_position <= row_position + RW'(1);
        if (filled != FW'(K_MAX)) filled <= filled + FW'(1);
      end
      if (cmd.row_end) begin
        remain <= k_eff;
        if (at_max) begin
          err <= topk_pkg::STATUS_LONG;
        end else if (count_new < CW'(k_eff)) begin
          err <= topk_pkg::STATUS_SHORT;
        end else begin
          err <= topk_pkg::STATUS_OK;
        end
      end else if (cmd.load) begin
        remain <= remain - FW'(1);
      end
    end
  end

  assign st.out_valid = out_valid;
  assign st.last_load = (err != topk_pkg::STATUS_OK) || (remain == FW'(1));

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (err != topk_pkg::STATUS_OK) begin
        out_data.value_out    <= '0;
        out_data.position_out <= '0;
        out_data.last_result  <= 1'b1;
        out_data.status       <= err;
      end else begin
        out_data.value_out    <= cell_value[0];
        out_data.position_out <= cell_pos[0];
        out_data.last_result  <= (remain == FW'(1));
        out_data.status       <= topk_pkg::STATUS_OK;
      end
    end
  end

endmodule

[test/tb_topk_select_with_indices.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_topk_select_with_indices
// Streams rows of signed values into the top-k selector. A scoreboard tracks
// the kept list per row and checks every result word field by field:
// directed corner rows first, then random rows under random backpressure,
// and finally one closing row at full k.
// ----------------------------------------------------------------------------
module tb_topk_select_with_indices;

  localparam int KEEP_DEPTH  = 16;
  localparam int ROW_LIMIT   = 65536;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_WORDS = 320;

  // index codes with no register behind them
  localparam logic [topk_pkg::CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [topk_pkg::CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

  localparam logic signed [topk_pkg::VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
  localparam logic signed [topk_pkg::VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

  typedef enum int {VAL_FULL, VAL_TIES, VAL_EDGE} value_mix_t;

  // --------------------------------------------------------------------------
  // scoreboard: tracks the best-first list of the open row
  // --------------------------------------------------------------------------
  class topk_scoreboard;
    logic [topk_pkg::SEL_COUNT_W-1:0]    select_k;
    logic                                keep_largest;
    logic signed [topk_pkg::VALUE_W-1:0] kept_value [KEEP_DEPTH];
    logic [topk_pkg::POS_W-1:0]          kept_pos   [KEEP_DEPTH];
    int                                  kept_count;
    int                                  row_count;
    topk_pkg::out_word_t                 expected_words [$];
    int                                  errors;

    function new();
      select_k     = topk_pkg::SELECT_COUNT_RESET;
      keep_largest = topk_pkg::PICK_LARGEST_RESET;
      kept_count   = 0;
      row_count    = 0;
      errors       = 0;
    endfunction

    function void write_reg(logic [topk_pkg::CFG_INDEX_W-1:0] idx,
                            logic [topk_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        topk_pkg::REG_SELECT_COUNT: select_k = data[topk_pkg::SEL_COUNT_W-1:0];
        topk_pkg::REG_PICK_LARGEST: keep_largest = data[0];
        default: ;
      endcase
    endfunction

    function bit outranks(logic signed [topk_pkg::VALUE_W-1:0] a,
                          logic signed [topk_pkg::VALUE_W-1:0] b);
      return keep_largest ? (a > b) : (a < b);
    endfunction

    // append one expected word at the tail
    function void queue_word(topk_pkg::out_word_t w);
      expected_words.insert(expected_words.size(), w);
    endfunction

    // compare-and-shift insertion; equal values stay behind earlier ones
    function void insert_element(logic signed [topk_pkg::VALUE_W-1:0] v,
                                 logic [topk_pkg::POS_W-1:0] p);
      int slot;
      int i;
      slot = kept_count;
      for (i = 0; i < kept_count; i++) begin
        if (outranks(v, kept_value[i])) begin
          slot = i;
          break;
        end
      end
      if (slot >= KEEP_DEPTH) return;
      for (i = (kept_count < KEEP_DEPTH) ? kept_count : KEEP_DEPTH - 1; i > slot; i--) begin
        kept_value[i] = kept_value[i-1];
        kept_pos[i]   = kept_pos[i-1];
      end
      kept_value[slot] = v;
      kept_pos[slot]   = p;
      if (kept_count < KEEP_DEPTH) kept_count++;
    endfunction

    function void note_input(topk_pkg::in_word_t w);
      int                  k;
      int                  i;
      bit                  overflow;
      topk_pkg::out_word_t r;
      overflow = 1'b0;
      if (row_count < ROW_LIMIT) begin
        insert_element(w.value, topk_pkg::POS_W'(row_count));
        row_count++;
      end else begin
        overflow = 1'b1;
      end
      if (!w.row_end) return;
      k = (select_k == 0) ? 1 : (select_k > KEEP_DEPTH) ? KEEP_DEPTH : int'(select_k);
      // error word: overlong wins over short
      if (overflow || row_count < k) begin
        r.value_out    = '0;
        r.position_out = '0;
        r.last_result  = 1'b1;
        r.status       = overflow ? topk_pkg::STATUS_LONG : topk_pkg::STATUS_SHORT;
        queue_word(r);
      end else begin
        for (i = 0; i < k; i++) begin
          r.value_out    = kept_value[i];
          r.position_out = kept_pos[i];
          r.last_result  = (i == k - 1);
          r.status       = topk_pkg::STATUS_OK;
          queue_word(r);
        end
      end
      kept_count = 0;
      row_count  = 0;
    endfunction

    function void check_result(topk_pkg::out_word_t got);
      topk_pkg::out_word_t want;
      if (expected_words.size() == 0) begin
        $error("unexpected result word: value_out %0d position_out %0d status %0d",
               got.value_out, got.position_out, got.status);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      if (got.value_out !== want.value_out) begin
        $error("value_out: expected %0d, got %0d", want.value_out, got.value_out);
        errors++;
      end
      if (got.position_out !== want.position_out) begin
        $error("position_out: expected %0d, got %0d", want.position_out, got.position_out);
        errors++;
      end
      if (got.last_result !== want.last_result) begin
        $error("last_result: expected %0d, got %0d", want.last_result, got.last_result);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic                             clk;
  logic                             rst;
  logic                             in_valid;
  logic                             in_ready;
  topk_pkg::in_word_t               in_data;
  logic                             out_valid;
  logic                             out_ready;
  topk_pkg::out_word_t              out_data;
  logic                             cfg_write;
  logic [topk_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [topk_pkg::CFG_DATA_W-1:0]  cfg_data;

  topk_scoreboard sb;
  bit             idle_on;
  bit             long_hold_req;

  topk_select_with_indices #(
    .K_MAX   (KEEP_DEPTH),
    .ROW_MAX (ROW_LIMIT)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [topk_pkg::VALUE_W-1:0] pick_value(value_mix_t mix);
    case (mix)
      VAL_TIES: return int'($urandom_range(0, 6)) - 3;
      VAL_EDGE: begin
        case ($urandom_range(0, 4))
          0: return VALUE_MIN;
          1: return VALUE_MAX;
          2: return 0;
          3: return -1;
          default: return 1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // one input word; valid stays up after acceptance until the next call
  task automatic send_word(input logic signed [topk_pkg::VALUE_W-1:0] v, input logic last);
    int                 gap;
    topk_pkg::in_word_t w;
    gap = idle_on ? pick_gap() : 0;
    w.value   = v;
    w.row_end = last;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  task automatic send_row(input int len, input value_mix_t mix);
    int i;
    for (i = 0; i < len; i++) send_word(pick_value(mix), i == len - 1);
  endtask

  task automatic stop_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // wait until every expected word has come back, then let the block settle
  task automatic settle();
    stop_input();
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [topk_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [topk_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // receiver: random stalls plus one long hold-off on request
  initial begin : rx_side
    int gap;
    int hold;
    gap  = 0;
    hold = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = 250;
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else if (gap > 0) begin
        out_ready <= 1'b0;
        gap--;
      end else begin
        out_ready <= 1'b1;
        if (idle_on) gap = pick_gap();
      end
    end
  end

  // handshake monitor
  always @(posedge clk) begin
    if (!rst && sb != null) begin
      if (in_valid && in_ready) sb.note_input(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  // run guard
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[topk_select_with_indices] ERROR");
    $finish;
  end

  initial begin : stimulus
    int                              random_words;
    int                              phase;
    int                              rows;
    int                              r;
    int                              i;
    int                              len;
    int                              keff;
    logic [topk_pkg::CFG_DATA_W-1:0] k_bits;
    logic [topk_pkg::CFG_DATA_W-1:0] pick_bits;

    sb            = new();
    idle_on       = 1'b1;
    long_hold_req = 1'b0;
    rst           = 1'b1;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_write     = 1'b0;
    cfg_index     = topk_pkg::REG_SELECT_COUNT;
    cfg_data      = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // reset config: single best, largest
    send_word(32'sd5, 1'b1);
    settle();

    // k=4, largest; extremes and a tie on the maximum
    write_reg(topk_pkg::REG_SELECT_COUNT, 5'd4);
    send_word(VALUE_MIN, 1'b0);
    send_word(VALUE_MAX, 1'b0);
    send_word(32'sd0, 1'b0);
    send_word(-32'sd1, 1'b0);
    send_word(VALUE_MAX, 1'b0);
    send_word(32'sd7, 1'b1);
    settle();

    // smallest, upper data bits set; then a short row
    write_reg(topk_pkg::REG_PICK_LARGEST, 5'b11110);
    send_word(32'sd3, 1'b0);
    send_word(VALUE_MIN, 1'b0);
    send_word(VALUE_MIN, 1'b0);
    send_word(VALUE_MAX, 1'b1);
    send_word(32'sd1, 1'b0);
    send_word(32'sd2, 1'b1);
    settle();

    // k of zero acts as one
    write_reg(topk_pkg::REG_SELECT_COUNT, 5'd0);
    send_word(32'sd9, 1'b0);
    send_word(-32'sd9, 1'b1);
    settle();

    // k above the depth clamps; spare indexes must not touch anything
    write_reg(topk_pkg::REG_SELECT_COUNT, 5'd31);
    write_reg(REG_SPARE_A, 5'd0);
    write_reg(REG_SPARE_B, 5'd31);
    send_word(32'sd4, 1'b0);
    send_word(32'sd4, 1'b0);
    send_word(32'sd4, 1'b1);
    settle();

    // random phases, new settings each phase
    random_words = 0;
    phase        = 0;
    while (random_words < RANDOM_WORDS) begin
      if (phase == 0) begin
        k_bits    = 5'd16;
        pick_bits = 5'd1;
      end else if (phase == 1) begin
        k_bits    = 5'd1;
        pick_bits = 5'd0;
      end else begin
        k_bits    = ($urandom_range(0, 3) == 0) ?
                    topk_pkg::CFG_DATA_W'($urandom_range(0, 31)) :
                    topk_pkg::CFG_DATA_W'($urandom_range(1, 16));
        pick_bits = topk_pkg::CFG_DATA_W'($urandom);
      end
      write_reg(topk_pkg::REG_SELECT_COUNT, k_bits);
      write_reg(topk_pkg::REG_PICK_LARGEST, pick_bits);
      keff    = (k_bits == 0) ? 1 : (k_bits > KEEP_DEPTH) ? KEEP_DEPTH : int'(k_bits);
      idle_on = (phase == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
      // receiver holds off while full rows keep coming
      if (phase == 0) long_hold_req = 1'b1;
      rows = $urandom_range(3, 6);
      for (i = 0; i < rows; i++) begin
        r = $urandom_range(0, 9);
        if (phase == 0)
          len = $urandom_range(17, 24);
        else if (r == 0 && keff > 1)
          len = $urandom_range(1, keff - 1);
        else if (r == 1)
          len = $urandom_range(20, 40);
        else
          len = $urandom_range(keff, keff + 8);
        send_row(len, value_mix_t'($urandom_range(0, 2)));
        random_words += len;
      end
      settle();
      phase++;
    end

    // closing row at full k, largest
    write_reg(topk_pkg::REG_SELECT_COUNT, 5'd16);
    write_reg(topk_pkg::REG_PICK_LARGEST, 5'd1);
    idle_on = 1'b1;
    send_row(20, VAL_FULL);

    settle();
    repeat (40) @(posedge clk);
    if (sb.errors == 0)
      $display("[topk_select_with_indices] OK");
    else
      $display("[topk_select_with_indices] ERROR");
    $finish;
  end

endmodule
